// ----- design/lsts_pkg.sv -----
package lsts_pkg;

  localparam int TIME_BITS = 16;
  localparam int SLOT_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON    = 1'b1;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_DONE  = 2'd1,
    ST_LATE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_P1,
    S_EVAL,
    S_P2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 req_type;
    logic [SLOT_W-1:0]    task_slot;
    logic [TIME_BITS-1:0] exec_time;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] deadline;
  } in_t;

  typedef struct packed {
    logic                 slot_valid;
    logic [SLOT_W-1:0]    slot_task;
    logic                 slot_idle;
    logic                 slot_late;
    logic [TIME_BITS:0]   switch_total;
    logic [TIME_BITS-1:0] preempt_total;
    logic                 run_done;
  } out_t;

  // One task table entry; next_rel is the next release tick.
  typedef struct packed {
    logic [TIME_BITS-1:0]        exec_time;
    logic [TIME_BITS-1:0]        period;
    logic [TIME_BITS-1:0]        deadline;
    logic [TIME_BITS-1:0]        work;
    logic signed [TIME_BITS+1:0] slack;
    status_t                     status;
    logic [TIME_BITS:0]          next_rel;
  } entry_t;

  localparam logic signed [TIME_BITS+1:0] SLACK_MIN = {1'b1, {(TIME_BITS+1){1'b0}}};

endpackage

// ----- design/lsts_ram.sv -----
module lsts_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output lsts_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  lsts_pkg::entry_t wr_data
);

  lsts_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/least_slack_time_scheduler.sv -----
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | lsts_pkg::in_t  (load or tick item)
// out_    | output    | out_valid/out_stall | lsts_pkg::out_t (one item per tick until the run is over)
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// On a tick the task table (one read, one write a cycle) is walked once over
// all entries (status, release, least slack search) and once over the n live
// entries (slack and work commit), n being the task count in use, plus the
// accept, evaluate and output steps.
// A load rewrites every entry's release mark.
// Reset is synchronous, active low; the task table itself is not cleared.
// The finished item sits in an output register, so the next input item is
// taken while it waits under out_stall.
module least_slack_time_scheduler #(
  parameter int MAX_TASKS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lsts_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lsts_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lsts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsts_pkg::TIME_BITS-1:0]     cfg_data
);

  localparam int TB = lsts_pkg::TIME_BITS;
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  lsts_pkg::state_t state_r, state_nxt;

  // configuration
  logic [5:0]    tc_r;
  logic [TB-1:0] horizon_r;

  // run state
  logic [TB-1:0] tick_r;
  logic [AW-1:0] ptask_r;
  logic          pidle_r, plate_r, run_over_r;
  logic [TB:0]   sw_r;
  logic [TB-1:0] pr_r;

  // per tick working registers
  logic                 final_r, found_r, best_late_r;
  logic [AW-1:0]        lst_r;
  logic signed [TB+1:0] best_r;
  logic [TB-1:0]        pw_r, pe_r;
  lsts_pkg::in_t        ld_r;
  lsts_pkg::out_t       res_r;

  // table walk
  logic [CW-1:0] cnt_r;
  logic          pipe_vld_r;
  logic [AW-1:0] pipe_idx_r;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr;
  lsts_pkg::entry_t rd_data, wr_data;

  logic             out_valid_r;
  lsts_pkg::out_t   out_data_r;

  logic          in_acc, out_free;
  logic [CW-1:0] n_w, limit;
  logic          walk_end;

  lsts_ram #(.DEPTH(MAX_TASKS), .AW(AW)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pipe_idx_r),
    .wr_data (wr_data)
  );

  assign in_stall  = (state_r != lsts_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // task count in use, clamped to 1..MAX_TASKS
  always_comb begin
    if (tc_r == 6'd0) begin
      n_w = CW'(1);
    end else if (32'(tc_r) > MAX_TASKS) begin
      n_w = CW'(MAX_TASKS);
    end else begin
      n_w = CW'(tc_r);
    end
  end

  assign limit    = (state_r == lsts_pkg::S_P2) ? n_w : CW'(MAX_TASKS);
  assign walk_end = (cnt_r == limit) && !pipe_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsts_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == lsts_pkg::REQ_LOAD) begin
            if (32'(in_data.task_slot) < MAX_TASKS) state_nxt = lsts_pkg::S_LOAD;
          end else if (!run_over_r) begin
            state_nxt = lsts_pkg::S_P1;
          end
        end
      end
      lsts_pkg::S_LOAD: if (walk_end) state_nxt = lsts_pkg::S_IDLE;
      lsts_pkg::S_P1:   if (walk_end) state_nxt = lsts_pkg::S_EVAL;
      lsts_pkg::S_EVAL: state_nxt = lsts_pkg::S_P2;
      lsts_pkg::S_P2:   if (walk_end) state_nxt = lsts_pkg::S_OUT;
      lsts_pkg::S_OUT:  if (out_free) state_nxt = lsts_pkg::S_IDLE;
      default:          state_nxt = lsts_pkg::S_IDLE;
    endcase
  end

  // read issue
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_r[AW-1:0];
    unique case (state_r)
      lsts_pkg::S_LOAD, lsts_pkg::S_P1, lsts_pkg::S_P2: rd_en = (cnt_r < limit);
      default: rd_en = 1'b0;
    endcase
  end

  // per-entry update on the data returned by the table
  logic                 i_pos, hit, in_use, cand, sel_here;
  lsts_pkg::entry_t     e;
  logic [TB:0]          rel_sum;

  always_comb begin
    e       = rd_data;
    i_pos   = (tick_r != '0);
    hit     = i_pos && (rd_data.period != '0) && ({1'b0, tick_r} == rd_data.next_rel);
    rel_sum = rd_data.next_rel + {1'b0, rd_data.period};
    in_use  = 32'(pipe_idx_r) < 32'(n_w);
    cand    = 1'b0;
    sel_here = (pipe_idx_r == lst_r);
    wr_en   = pipe_vld_r;
    case (state_r)
      lsts_pkg::S_LOAD: begin
        if (pipe_idx_r == AW'(ld_r.task_slot)) begin
          e.exec_time = ld_r.exec_time;
          e.period    = ld_r.period;
          e.deadline  = ld_r.deadline;
          e.work      = ld_r.exec_time;
          e.slack     = $signed({2'b00, ld_r.deadline}) - $signed({2'b00, ld_r.exec_time});
          e.status    = lsts_pkg::ST_READY;
          e.next_rel  = {1'b0, ld_r.period};
        end else begin
          e.next_rel  = {1'b0, rd_data.period};
        end
      end
      lsts_pkg::S_P1: begin
        if (in_use) begin
          if (rd_data.work != '0 && rd_data.slack < 0 && i_pos) begin
            e.status = lsts_pkg::ST_LATE;
          end else if (rd_data.work == '0) begin
            e.status = lsts_pkg::ST_DONE;
          end
          if (hit && e.status != lsts_pkg::ST_LATE) begin
            e.work   = rd_data.exec_time;
            e.slack  = $signed({2'b00, rd_data.deadline}) - $signed({2'b00, rd_data.exec_time});
            e.status = lsts_pkg::ST_READY;
          end
          cand = (e.status != lsts_pkg::ST_DONE) && (!found_r || e.slack < best_r);
        end
        if (hit) e.next_rel = rel_sum;
      end
      lsts_pkg::S_P2: begin
        if (!sel_here && rd_data.status != lsts_pkg::ST_DONE &&
            rd_data.slack != lsts_pkg::SLACK_MIN) begin
          e.slack = rd_data.slack - 18'sd1;
        end
        if (sel_here && found_r && !final_r && rd_data.work != '0) begin
          e.work = rd_data.work - TB'(1);
        end
      end
      default: wr_en = 1'b0;
    endcase
    wr_data = e;
  end

  // tallies against the previous slot
  logic        done_sel, late_sel, same_id, same_idd, idle0, b1, idle2;
  logic [1:0]  sw_add;
  logic        pr_add;
  logic [TB+1:0] sw_sum;
  logic [TB:0]   pr_sum;

  always_comb begin
    done_sel = !found_r;
    late_sel = found_r && best_late_r;
    same_id  = !pidle_r && (ptask_r == lst_r) && !plate_r;
    same_idd = !pidle_r && (ptask_r == lst_r) && plate_r;
    idle0    = pidle_r && done_sel;
    b1       = i_pos && done_sel && !idle0;
    idle2    = idle0;
    sw_add   = 2'd0;
    pr_add   = 1'b0;
    if (b1) begin
      if (!final_r) begin
        idle2  = 1'b1;
        pr_add = 1'b1;
        sw_add = 2'd1;
      end
    end else if (i_pos && !same_id) begin
      if (!pidle_r && 32'(ptask_r) < 32'(n_w) && pw_r != '0 && pw_r < pe_r) pr_add = 1'b1;
    end
    if (!late_sel && i_pos && same_idd) sw_add = sw_add + 2'd1;
    if (i_pos && !same_id && !same_idd && !idle2) sw_add = sw_add + 2'd1;
    sw_sum = {1'b0, sw_r} + (TB+2)'(sw_add);
    pr_sum = {1'b0, pr_r} + (TB+1)'(pr_add);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsts_pkg::S_IDLE;
      tc_r        <= 6'd1;
      horizon_r   <= '0;
      tick_r      <= '0;
      ptask_r     <= '0;
      pidle_r     <= 1'b0;
      plate_r     <= 1'b0;
      run_over_r  <= 1'b0;
      sw_r        <= '0;
      pr_r        <= '0;
      cnt_r       <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pipe_vld_r <= rd_en;
      if (rd_en) cnt_r <= cnt_r + CW'(1);

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lsts_pkg::CFG_TASK_COUNT: tc_r      <= cfg_data[5:0];
          lsts_pkg::CFG_HORIZON:    horizon_r <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == lsts_pkg::S_IDLE && state_nxt != lsts_pkg::S_IDLE) begin
        cnt_r <= '0;
        if (in_data.req_type == lsts_pkg::REQ_LOAD) begin
          tick_r     <= '0;
          ptask_r    <= '0;
          pidle_r    <= 1'b0;
          plate_r    <= 1'b0;
          sw_r       <= '0;
          pr_r       <= '0;
          run_over_r <= 1'b0;
        end
      end

      if (state_r == lsts_pkg::S_EVAL) begin
        cnt_r <= '0;
        sw_r  <= sw_sum[TB+1] ? '1 : sw_sum[TB:0];
        pr_r  <= pr_sum[TB]   ? '1 : pr_sum[TB-1:0];
        if (!final_r) begin
          tick_r  <= tick_r + TB'(1);
          pidle_r <= done_sel;
          ptask_r <= done_sel ? '0 : lst_r;
          plate_r <= late_sel;
        end else begin
          run_over_r <= 1'b1;
        end
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == lsts_pkg::S_OUT && out_free) out_valid_r <= 1'b1;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    pipe_idx_r <= rd_addr;
    if (state_r == lsts_pkg::S_IDLE) begin
      ld_r    <= in_data;
      final_r <= (tick_r >= horizon_r);
      found_r <= 1'b0;
      lst_r   <= '0;
    end
    if (state_r == lsts_pkg::S_P1 && pipe_vld_r) begin
      if (cand) begin
        found_r     <= 1'b1;
        lst_r       <= pipe_idx_r;
        best_r      <= e.slack;
        best_late_r <= (e.status == lsts_pkg::ST_LATE);
      end
      if (in_use && pipe_idx_r == ptask_r) begin
        pw_r <= e.work;
        pe_r <= e.exec_time;
      end
    end
    if (state_r == lsts_pkg::S_EVAL) begin
      res_r.slot_valid    <= !final_r;
      res_r.slot_task     <= (final_r || done_sel) ? '0 : lsts_pkg::SLOT_W'(lst_r);
      res_r.slot_idle     <= !final_r && done_sel;
      res_r.slot_late     <= !final_r && late_sel;
      res_r.switch_total  <= sw_sum[TB+1] ? '1 : sw_sum[TB:0];
      res_r.preempt_total <= pr_sum[TB] ? '1 : pr_sum[TB-1:0];
      res_r.run_done      <= final_r;
    end
    if (state_r == lsts_pkg::S_OUT && out_free) out_data_r <= res_r;
  end

  a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(rd_en))
    else $error("table write without a read one cycle before");

  a_lst_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsts_pkg::S_EVAL && found_r) |-> (32'(lst_r) < 32'(n_w)))
    else $error("selected task outside the tasks in use");

  a_sw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lsts_pkg::S_IDLE) |=> (sw_r >= $past(sw_r)))
    else $error("switch tally fell during a tick");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsts_pkg::S_P2 && pipe_vld_r) |-> (32'(pipe_idx_r) < 32'(n_w)))
    else $error("commit walk beyond the tasks in use");

endmodule

// ----- test/tb_top.sv -----
module tb_top;

  localparam int NTASK = 32;
  localparam int SLACK_FLOOR = -131072;
  localparam int SW_CAP = 131071;
  localparam int PR_CAP = 65535;
  localparam int SETTLE = 100;
  localparam int IW = lsts_pkg::CFG_IDX_W;
  localparam int TW = lsts_pkg::TIME_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lsts_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lsts_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = lsts_pkg::CFG_TASK_COUNT;
  logic [TW-1:0] cfg_data = '0;

  least_slack_time_scheduler dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the scheduler
  logic [15:0] sh_exec[NTASK], sh_period[NTASK], sh_dl[NTASK], sh_work[NTASK];
  int          sh_slack[NTASK];
  lsts_pkg::status_t sh_status[NTASK];
  logic [15:0] sh_tick;
  int          sh_prev_task;
  bit          sh_prev_idle, sh_prev_late, sh_over;
  int          sh_switches, sh_preempts;
  logic [5:0]  sh_count;
  logic [15:0] sh_horizon;

  lsts_pkg::out_t slot_queue[$];
  int   errors = 0;
  int   mode = 0;       // 0: sender idles 20%, receiver 75%; 1: swapped; 2: none
  bit   hold_req = 0;   // ask receiver for one long hold-off

  function automatic void release_entry(int j);
    sh_work[j]   = sh_exec[j];
    sh_slack[j]  = int'(sh_dl[j]) - int'(sh_exec[j]);
    sh_status[j] = lsts_pkg::ST_READY;
  endfunction

  function automatic void clear_run();
    sh_tick = '0; sh_prev_task = 0; sh_prev_idle = 0; sh_prev_late = 0;
    sh_switches = 0; sh_preempts = 0; sh_over = 0;
  endfunction

  // Advance the shadow by one item; returns 1 with the slot result for a tick of a run not yet over.
  function automatic bit schedule_item(lsts_pkg::in_t x, output lsts_pkg::out_t r);
    int n, i, lst, k;
    bit fin, done_sel, late_sel, same_id, same_idd, idle;
    r = '0;
    if (x.req_type == lsts_pkg::REQ_LOAD) begin
      sh_exec[x.task_slot]   = x.exec_time;
      sh_period[x.task_slot] = x.period;
      sh_dl[x.task_slot]     = x.deadline;
      release_entry(x.task_slot);
      clear_run();
      return 0;
    end
    if (sh_over) return 0;
    n = (sh_count == 0) ? 1 : (sh_count > NTASK) ? NTASK : sh_count;
    i = sh_tick;
    fin = i >= sh_horizon;
    for (int j = 0; j < n; j++) begin
      if (sh_work[j] > 0 && sh_slack[j] < 0 && i > 0) sh_status[j] = lsts_pkg::ST_LATE;
      else if (sh_work[j] == 0) sh_status[j] = lsts_pkg::ST_DONE;
      if (i > 0 && sh_period[j] != 0 && (i % sh_period[j]) == 0 &&
          sh_status[j] != lsts_pkg::ST_LATE)
        release_entry(j);
    end
    lst = 0;
    for (int j = 0; j < n; j++)
      if (sh_status[j] != lsts_pkg::ST_DONE) begin
        lst = j;
        break;
      end
    for (int j = 0; j < n; j++)
      if (sh_status[j] != lsts_pkg::ST_DONE && sh_slack[j] < sh_slack[lst]) lst = j;
    done_sel = sh_status[lst] == lsts_pkg::ST_DONE;
    late_sel = sh_status[lst] == lsts_pkg::ST_LATE;
    // tallies against previous slot
    same_id  = !sh_prev_idle && sh_prev_task == lst && !sh_prev_late;
    same_idd = !sh_prev_idle && sh_prev_task == lst && sh_prev_late;
    idle = sh_prev_idle && done_sel;
    if (i > 0 && done_sel && !idle) begin
      if (!fin) begin
        idle = 1;
        if (sh_preempts < PR_CAP) sh_preempts++;
        if (sh_switches < SW_CAP) sh_switches++;
      end
    end else if (i > 0 && !same_id) begin
      // idle or out-of-range previous slot counts no preemption
      if (!sh_prev_idle && sh_prev_task < n) begin
        k = sh_prev_task;
        if (sh_work[k] > 0 && sh_work[k] < sh_exec[k] && sh_preempts < PR_CAP) sh_preempts++;
      end
    end
    if (!late_sel && i > 0 && same_idd && sh_switches < SW_CAP) sh_switches++;
    if (i > 0 && !same_id && !same_idd && !idle && sh_switches < SW_CAP) sh_switches++;
    for (int j = 0; j < n; j++)
      if (j != lst && sh_status[j] != lsts_pkg::ST_DONE && sh_slack[j] > SLACK_FLOOR)
        sh_slack[j]--;
    r.switch_total  = 17'(sh_switches);
    r.preempt_total = 16'(sh_preempts);
    if (!fin) begin
      if (done_sel) begin
        sh_prev_idle = 1; sh_prev_task = 0; sh_prev_late = 0;
      end else begin
        if (sh_work[lst] > 0) sh_work[lst]--;
        sh_prev_idle = 0; sh_prev_task = lst; sh_prev_late = late_sel;
      end
      sh_tick = sh_tick + 16'd1;
      r.slot_valid = 1;
      r.slot_task  = 5'(sh_prev_task);
      r.slot_idle  = sh_prev_idle;
      r.slot_late  = sh_prev_late;
    end else begin
      sh_over = 1;
      r.run_done = 1;
    end
    return 1;
  endfunction

  // offer one item; typed expectation replaces the prediction when given
  task automatic send_item(lsts_pkg::in_t x, bit typed = 0, lsts_pkg::out_t want = '0);
    lsts_pkg::out_t r;
    while ((mode == 0 && $urandom_range(99) < 20) ||
           (mode == 1 && $urandom_range(99) < 75)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (schedule_item(x, r)) slot_queue.push_back(typed ? want : r);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (slot_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lsts_pkg::CFG_TASK_COUNT) sh_count = val[5:0];
    else sh_horizon = val;
    @(posedge clk);
  endtask

  function automatic lsts_pkg::in_t load_of(int s, int e, int p, int d);
    lsts_pkg::in_t x;
    x.req_type = lsts_pkg::REQ_LOAD; x.task_slot = 5'(s);
    x.exec_time = 16'(e); x.period = 16'(p); x.deadline = 16'(d);
    return x;
  endfunction

  function automatic lsts_pkg::in_t tick_of();
    lsts_pkg::in_t x;
    x.req_type  = lsts_pkg::REQ_TICK;
    x.task_slot = 5'($urandom);
    x.exec_time = 16'($urandom);
    x.period    = 16'($urandom);
    x.deadline  = 16'($urandom);
    return x;
  endfunction

  function automatic lsts_pkg::in_t random_load(int s);
    if ($urandom_range(9) == 0)
      return load_of(s, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    return load_of(s, $urandom_range(5), $urandom_range(12), $urandom_range(15));
  endfunction

  // receiver: random stall per mode, plus one long hold-off on request
  always @(posedge clk) begin
    static int hold = 0;
    if (hold_req && hold == 0) begin
      hold = 400;
      hold_req = 0;
    end
    if (hold > 0) begin
      hold--;
      out_stall <= 1'b1;
    end else if (mode == 0) out_stall <= $urandom_range(99) < 75;
    else if (mode == 1) out_stall <= $urandom_range(99) < 20;
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    lsts_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (slot_queue.size() == 0) begin
        $error("slot result with nothing expected: %h", out_data);
        errors++;
      end else begin
        e = slot_queue.pop_front();
        if (out_data.slot_valid !== e.slot_valid) begin
          $error("slot_valid exp %0d got %0d", e.slot_valid, out_data.slot_valid); errors++;
        end
        if (out_data.slot_task !== e.slot_task) begin
          $error("slot_task exp %0d got %0d", e.slot_task, out_data.slot_task); errors++;
        end
        if (out_data.slot_idle !== e.slot_idle) begin
          $error("slot_idle exp %0d got %0d", e.slot_idle, out_data.slot_idle); errors++;
        end
        if (out_data.slot_late !== e.slot_late) begin
          $error("slot_late exp %0d got %0d", e.slot_late, out_data.slot_late); errors++;
        end
        if (out_data.switch_total !== e.switch_total) begin
          $error("switch_total exp %0d got %0d", e.switch_total, out_data.switch_total);
          errors++;
        end
        if (out_data.preempt_total !== e.preempt_total) begin
          $error("preempt_total exp %0d got %0d", e.preempt_total, out_data.preempt_total);
          errors++;
        end
        if (out_data.run_done !== e.run_done) begin
          $error("run_done exp %0d got %0d", e.run_done, out_data.run_done); errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("tb_top failed");
    $finish;
  end

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t      kind;
    lsts_pkg::in_t  item;
    bit             typed;
    lsts_pkg::out_t want;
  } row_t;

  initial begin
    row_t rows[$];
    row_t rw;
    int sent, n, ticks;
    bit press;
    for (int j = 0; j < NTASK; j++) begin
      sh_exec[j] = 0; sh_period[j] = 0; sh_dl[j] = 0; sh_work[j] = 0;
      sh_slack[j] = 0; sh_status[j] = lsts_pkg::ST_READY;
    end
    clear_run();
    sh_count = 1;
    sh_horizon = 0;

    // directed rows; cfg rows carry the register index in task_slot and value in exec_time
    rw = '{ROW_ITEM, load_of(0, 0, 0, 0), 0, '0};                          rows.push_back(rw);
    rw = '{ROW_ITEM, tick_of(), 1, '{0, 0, 0, 0, 0, 0, 1}};                 rows.push_back(rw);
    rw = '{ROW_ITEM, tick_of(), 0, '0};                                     rows.push_back(rw);
    rw = '{ROW_CFG, load_of(lsts_pkg::CFG_HORIZON, 5, 0, 0), 0, '0};        rows.push_back(rw);
    rw = '{ROW_ITEM, load_of(0, 2, 3, 2), 0, '0};                           rows.push_back(rw);
    rw = '{ROW_ITEM, tick_of(), 1, '{1, 0, 0, 0, 0, 0, 0}};                 rows.push_back(rw);
    repeat (3) begin rw = '{ROW_ITEM, tick_of(), 0, '0}; rows.push_back(rw); end
    // horizon lowered below the tick count ends the run at once
    rw = '{ROW_CFG, load_of(lsts_pkg::CFG_HORIZON, 2, 0, 0), 0, '0};        rows.push_back(rw);
    repeat (2) begin rw = '{ROW_ITEM, tick_of(), 0, '0}; rows.push_back(rw); end
    rw = '{ROW_CFG, load_of(lsts_pkg::CFG_TASK_COUNT, 0, 0, 0), 0, '0};     rows.push_back(rw);
    rw = '{ROW_CFG, load_of(lsts_pkg::CFG_HORIZON, 65535, 0, 0), 0, '0};    rows.push_back(rw);
    rw = '{ROW_ITEM, load_of(31, 65535, 65535, 65535), 0, '0};             rows.push_back(rw);
    rw = '{ROW_ITEM, load_of(0, 65535, 1, 0), 0, '0};                       rows.push_back(rw);
    repeat (3) begin rw = '{ROW_ITEM, tick_of(), 0, '0}; rows.push_back(rw); end
    // zero work released every tick
    rw = '{ROW_CFG, load_of(lsts_pkg::CFG_TASK_COUNT, 2, 0, 0), 0, '0};     rows.push_back(rw);
    rw = '{ROW_ITEM, load_of(1, 0, 1, 0), 0, '0};                           rows.push_back(rw);
    rw = '{ROW_ITEM, load_of(0, 3, 0, 1), 0, '0};                           rows.push_back(rw);
    repeat (5) begin rw = '{ROW_ITEM, tick_of(), 0, '0}; rows.push_back(rw); end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    mode = 2;
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(IW'(rows[r].item.task_slot), rows[r].item.exec_time);
      end else send_item(rows[r].item, rows[r].typed, rows[r].want);
    end

    // random phases: well-formed runs with random content
    sent = 0;
    while (sent < 1750) begin
      wait_quiet();
      press = 1'b0;
      if (sent < 600) mode = 0;
      else if (sent < 1200) mode = 1;
      else begin
        press = (mode != 2);
        mode = 2;
      end
      // the first run without idling is long and narrow so a hold-off fills the block
      if (press) write_reg(lsts_pkg::CFG_TASK_COUNT, 16'd4);
      else begin
        case ($urandom_range(9))
          0: write_reg(lsts_pkg::CFG_TASK_COUNT, 16'd0);
          1: write_reg(lsts_pkg::CFG_TASK_COUNT, 16'd32);
          2: write_reg(lsts_pkg::CFG_TASK_COUNT, 16'($urandom_range(65535)));
          default: write_reg(lsts_pkg::CFG_TASK_COUNT, 16'($urandom_range(1, 8)));
        endcase
      end
      if (press) write_reg(lsts_pkg::CFG_HORIZON, 16'hFFFF);
      else begin
        case ($urandom_range(9))
          0: write_reg(lsts_pkg::CFG_HORIZON, 16'd0);
          1: write_reg(lsts_pkg::CFG_HORIZON, 16'hFFFF);
          default: write_reg(lsts_pkg::CFG_HORIZON, 16'($urandom_range(3, 60)));
        endcase
      end
      n = (sh_count == 0) ? 1 : (sh_count > NTASK) ? NTASK : sh_count;
      for (int j = 0; j < n; j++) begin
        send_item(random_load(j));
        sent++;
      end
      ticks = $urandom_range(10, 60);
      if (press) hold_req = 1;
      repeat (ticks) begin
        if ($urandom_range(9) == 0) send_item(random_load($urandom_range(31)));
        else send_item(tick_of());
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (slot_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/lsts_pkg.sv
design/lsts_ram.sv
design/least_slack_time_scheduler.sv
test/tb_top.sv
